// File: rtl/civil_date_to_day_number_macros.svh
// Assertion macros used by the checker file cd2dn_checker.sv.
`ifndef CIVIL_DATE_TO_DAY_NUMBER_MACROS_SVH
`define CIVIL_DATE_TO_DAY_NUMBER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CD2DN_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication from an accepted word to its result, across the pipeline.
`define CD2DN_ASSERT_LAT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##4 (cons)) \
        else $error(msg);

`endif

// File: rtl/cd2dn_pkg.sv
`default_nettype none

package cd2dn_pkg;

    localparam logic signed [23:0] YEAR_MAX = 24'sd5000000;
    localparam logic signed [23:0] YEAR_MIN = -24'sd5000000;

    // Multiple of 400 that lifts every in-range year to a positive value,
    // so floor division becomes plain unsigned division.
    localparam logic [25:0] ERA_OFFSET = 26'd5200000;

    // ceil(2^32 / 25); exact floor(v / 25) for v below 2^22
    localparam logic [27:0] RECIP_25 = 28'd171798692;

    // -(5200000/4) + 5200000/100 - 5200000/400 - 719468 = -1980468
    localparam logic [31:0] SUM_BIAS = 32'hFFE1_C7CC;

    localparam logic [31:0] INVALID_DAY_NUMBER = 32'h8000_0000;

    typedef struct packed {
        logic [23:0] u;        // shifted March-based year
        logic [24:0] yy;       // March-based year, two's complement
        logic [8:0]  doy;      // day of March-based year
        logic        base_ok;  // date valid without the leap day
        logic        feb29;    // in-range year, February 29th
    } front_t;

    typedef struct packed {
        logic [17:0] q;        // floor(u / 100)
        logic [23:0] u;
        logic [8:0]  doy;
        logic [31:0] yy365;
        logic        base_ok;
        logic        feb29;
    } mid_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // days from March 1st to the first of the month
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd3:    n = 9'd0;
            4'd4:    n = 9'd31;
            4'd5:    n = 9'd61;
            4'd6:    n = 9'd92;
            4'd7:    n = 9'd122;
            4'd8:    n = 9'd153;
            4'd9:    n = 9'd184;
            4'd10:   n = 9'd214;
            4'd11:   n = 9'd245;
            4'd12:   n = 9'd275;
            4'd1:    n = 9'd306;
            4'd2:    n = 9'd337;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cd2dn_front.sv
`default_nettype none

module cd2dn_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic signed [23:0]  year,
    input  wire logic [3:0]          month,
    input  wire logic [4:0]          day,
    output logic                     out_valid,
    output cd2dn_pkg::front_t        out_data
);

    logic               valid_reg;
    cd2dn_pkg::front_t  data_reg;
    cd2dn_pkg::front_t  data_next;

    logic        jan_feb;
    logic [25:0] y_ext;
    logic [25:0] u_full;
    logic        year_ok;
    logic        month_ok;
    logic        day_ok;

    always_comb
    begin
        jan_feb  = (month == 4'd1) || (month == 4'd2);
        y_ext    = {{2{year[23]}}, year};
        u_full   = y_ext - 26'(jan_feb) + cd2dn_pkg::ERA_OFFSET;
        year_ok  = (year <= cd2dn_pkg::YEAR_MAX) && (year >= cd2dn_pkg::YEAR_MIN);
        month_ok = (month >= 4'd1) && (month <= 4'd12);
        day_ok   = (day != 5'd0) && (day <= cd2dn_pkg::month_len(month));

        data_next.u       = u_full[23:0];
        data_next.yy      = y_ext[24:0] - 25'(jan_feb);
        data_next.doy     = cd2dn_pkg::days_before(month) + 9'(day) - 9'd1;
        data_next.base_ok = year_ok && month_ok && day_ok;
        data_next.feb29   = year_ok && (month == 4'd2) && (day == 5'd29);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/cd2dn_mul.sv
`default_nettype none

module cd2dn_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire cd2dn_pkg::front_t  in_data,
    output logic                    out_valid,
    output cd2dn_pkg::mid_t         out_data
);

    logic             valid_reg;
    cd2dn_pkg::mid_t  data_reg;
    cd2dn_pkg::mid_t  data_next;

    logic [49:0] recip_prod;
    logic [33:0] yy365_full;

    always_comb
    begin
        // floor(u / 100) = floor((u >> 2) / 25)
        recip_prod = 50'(in_data.u[23:2]) * 50'(cd2dn_pkg::RECIP_25);
        yy365_full = {{9{in_data.yy[24]}}, in_data.yy} * 34'd365;

        data_next.q       = recip_prod[49:32];
        data_next.u       = in_data.u;
        data_next.doy     = in_data.doy;
        data_next.yy365   = yy365_full[31:0];
        data_next.base_ok = in_data.base_ok;
        data_next.feb29   = in_data.feb29;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/cd2dn_back.sv
`default_nettype none

module cd2dn_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire cd2dn_pkg::mid_t   in_data,
    output logic                   done,
    output logic signed [31:0]     day_number,
    output logic                   date_valid
);

    logic        valid_reg;
    logic [31:0] sum_reg;
    logic [31:0] sum_next;
    logic [17:0] q_reg;
    logic        ok_reg;
    logic        ok_next;

    logic        done_reg;
    logic [31:0] dn_reg;
    logic [31:0] dn_next;
    logic        dv_reg;

    logic [6:0]  q100_lo;
    logic [6:0]  rem;
    logic        leap;

    always_comb
    begin
        // u mod 100 needs only the low seven bits, as it stays below 128
        q100_lo = in_data.q[6:0] * 7'd100;
        rem     = in_data.u[6:0] - q100_lo;
        // year = u + 1 - offset: leap when divisible by 4 and not by 100,
        // or by 400 (then q + 1 is a multiple of 4)
        leap    = (in_data.u[1:0] == 2'b11)
                  && ((rem != 7'd99) || (in_data.q[1:0] == 2'b11));
        ok_next  = in_data.base_ok || (in_data.feb29 && leap);
        sum_next = in_data.yy365 + 32'(in_data.u[23:2]) + 32'(in_data.doy)
                   + cd2dn_pkg::SUM_BIAS;

        dn_next = sum_reg - 32'(q_reg) + 32'(q_reg[17:2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        q_reg   <= in_data.q;
        ok_reg  <= ok_next;
        dn_reg  <= ok_reg ? dn_next : cd2dn_pkg::INVALID_DAY_NUMBER;
        dv_reg  <= ok_reg;
    end

    assign done       = done_reg;
    assign day_number = $signed(dn_reg);
    assign date_valid = dv_reg;

endmodule

`default_nettype wire

// File: rtl/civil_date_to_day_number.sv
`default_nettype none

// Gregorian date to signed day count since 1970-01-01.
//
// Input: a word is taken at a rising edge with start high and busy low.
// busy is held low, so a new date may be given in every cycle.
// Output: done pulses for one cycle with day_number and date_valid; the
// receiver cannot stall, and results leave in the order dates came in.
// Throughput is one word per cycle through the four register stages:
// range checks and month tables, the two multipliers (u / 100 by
// reciprocal and year * 365), the leap test and sum, then the final add.
// An invalid date (year outside -5000000..5000000, month outside 1..12,
// day outside the month) gives day_number 0x80000000 and date_valid low.
// Reset clears the valid bits of every stage: words in flight are dropped
// and done stays low until new words arrive.

module civil_date_to_day_number (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic signed [23:0]  year,
    input  wire logic [3:0]          month,
    input  wire logic [4:0]          day,
    output logic                     done,
    output logic signed [31:0]       day_number,
    output logic                     date_valid
);

    logic               accept;
    logic               front_valid;
    cd2dn_pkg::front_t  front_data;
    logic               mid_valid;
    cd2dn_pkg::mid_t    mid_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cd2dn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .year      (year),
        .month     (month),
        .day       (day),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    cd2dn_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (mid_valid),
        .out_data  (mid_data)
    );

    cd2dn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mid_valid),
        .in_data    (mid_data),
        .done       (done),
        .day_number (day_number),
        .date_valid (date_valid)
    );

endmodule

`default_nettype wire

// File: rtl/cd2dn_checker.sv
`default_nettype none

`include "civil_date_to_day_number_macros.svh"

module cd2dn_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic [3:0]          month,
    input wire logic                done,
    input wire logic signed [31:0]  day_number,
    input wire logic                date_valid
);

    logic marker;
    logic bad_month;

    assign marker    = ($unsigned(day_number) == cd2dn_pkg::INVALID_DAY_NUMBER);
    assign bad_month = (month == 4'd0) || (month > 4'd12);

    `CD2DN_ASSERT_LAT(a_done_follows, start && !busy, done, "accepted word gave no result")
    `CD2DN_ASSERT_LAT(a_no_spurious, !(start && !busy), !done, "result without a word")
    `CD2DN_ASSERT_IMPL(a_invalid_code, done && !date_valid, marker, "invalid without marker")
    `CD2DN_ASSERT_IMPL(a_valid_not_code, done && date_valid, !marker, "valid with marker")
    `CD2DN_ASSERT_LAT(a_bad_month, start && !busy && bad_month, !date_valid, "bad month valid")

endmodule

bind civil_date_to_day_number cd2dn_checker u_cd2dn_checker (.*);

`default_nettype wire
